// File: hdl/cstt_pkg.sv
// Shared constants for the color step block.
package cstt_pkg;
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int STEP_BITS        = 9;
    localparam int STEP_RESET       = 16;
    localparam int Q_BITS           = 9;
    localparam int Q2_BITS          = 2 * Q_BITS;
    localparam int SEARCH_STAGES    = Q_BITS;
    localparam int FRONT_STAGES     = 3;
    localparam int PIPE_STAGES      = FRONT_STAGES + SEARCH_STAGES;
    localparam int APB_ADDR_BITS    = 3;
    localparam int APB_DATA_BITS    = 32;
    localparam logic REG_STEP_AMOUNT = 1'b0;
endpackage

// File: hdl/color_step_toward_target.sv
// Top level of the color step block: stream ports, step register, lanes and merge.
//
// Usage: each request on the slave stream carries a current pixel and a target
// color. The block moves the pixel toward the target by at most step_amount in
// Euclidean distance and returns the new pixel on the master stream, with
// tuser set when the pixel snapped to the target.
// Three lanes, one per channel, run in parallel; the merge stage sums their
// squared deltas and picks between the target and the stepped pixel.
// Throughput is one pixel per cycle while the master side does not stall; the
// bitwise search for the step length is a 9-stage pipeline in each lane, one
// bit of the step per stage.
// When the master side stalls with a result held in the output register, the
// whole pipeline holds and o_s_tready goes low in the same cycle.
// step_amount is written over the APB port at any address with paddr[2] low
// (0 to 3) and reads back there; write it only while no pixel is in flight.
// Reset (synchronous, active low) empties the pipeline and sets step_amount
// to 16.
module color_step_toward_target #(
    parameter int CHANNEL_BITS = cstt_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // cur_red, cur_green, cur_blue, goal_red, goal_green, goal_blue, zero fill
    input  logic [((6*CHANNEL_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // new_red, new_green, new_blue, zero fill
    output logic [((3*CHANNEL_BITS+7)/8)*8-1:0] o_m_tdata,
    // reached_goal
    output logic                                o_m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cstt_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [cstt_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [cstt_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    localparam int CB  = CHANNEL_BITS;
    localparam int SW  = 2 * CB + 2;
    localparam int STW = cstt_pkg::STEP_BITS;
    localparam int SQW = 2 * STW;
    localparam int CW  = (SW > SQW) ? SW : SQW;
    localparam int QW  = cstt_pkg::Q_BITS;
    localparam int NP  = cstt_pkg::PIPE_STAGES;
    localparam int FS  = cstt_pkg::FRONT_STAGES;
    localparam int OW  = ((3*CB+7)/8)*8;

    logic [STW-1:0] r_step;
    logic [SQW-1:0] r_step_sq;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite
                    && (paddr[cstt_pkg::APB_ADDR_BITS-1] == cstt_pkg::REG_STEP_AMOUNT);
    assign prdata = (paddr[cstt_pkg::APB_ADDR_BITS-1] == cstt_pkg::REG_STEP_AMOUNT)
                    ? cstt_pkg::APB_DATA_BITS'(r_step) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= STW'(cstt_pkg::STEP_RESET);
            r_step_sq <= SQW'(cstt_pkg::STEP_RESET * cstt_pkg::STEP_RESET);
        end else if (w_wr) begin
            r_step    <= pwdata[STW-1:0];
            r_step_sq <= SQW'(pwdata[STW-1:0]) * SQW'(pwdata[STW-1:0]);
        end
    end

    logic w_ce;
    logic r_out_valid;
    assign w_ce       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_ce;
    assign o_m_tvalid = r_out_valid;

    logic [2*CB-1:0] w_sq  [0:2];
    logic [CB-1:0]   w_cur [0:2];
    logic [CB-1:0]   w_goal[0:2];
    logic            w_dir [0:2];
    logic [QW-1:0]   w_q   [0:2];
    logic [SW-1:0]   r_sum3;

    for (genvar c = 0; c < 3; c++) begin : g_lane
        cstt_lane #(.CHANNEL_BITS(CB)) u_lane (
            .i_clk  (i_clk),
            .i_ce   (w_ce),
            .i_cur  (i_s_tdata[c*CB +: CB]),
            .i_goal (i_s_tdata[(c+3)*CB +: CB]),
            .i_step (r_step),
            .o_sq   (w_sq[c]),
            .i_sum  (r_sum3),
            .o_cur  (w_cur[c]),
            .o_goal (w_goal[c]),
            .o_dir  (w_dir[c]),
            .o_q    (w_q[c])
        );
    end

    logic r_vld [1:NP];
    logic r_near[FS+1:NP];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_sum3 <= SW'(w_sq[0]) + SW'(w_sq[1]) + SW'(w_sq[2]);
            r_near[FS+1] <= (CW'(r_sum3) <= CW'(r_step_sq));
            for (int s = FS + 2; s <= NP; s++) begin
                r_near[s] <= r_near[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= NP; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_ce) begin
            r_vld[1] <= i_s_tvalid;
            for (int s = 2; s <= NP; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_out_valid <= r_vld[NP];
        end
    end

    // Merge: snap to the target when within reach, else apply the signed step.
    logic [CB-1:0] n_new [0:2];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_near[NP]) begin
                n_new[c] = w_goal[c];
            end else if (w_dir[c]) begin
                n_new[c] = CB'(w_cur[c] + CB'(w_q[c]));
            end else begin
                n_new[c] = CB'(w_cur[c] - CB'(w_q[c]));
            end
        end
    end

    logic [OW-1:0] r_tdata;
    logic          r_tuser;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_tdata <= OW'({n_new[2], n_new[1], n_new[0]});
            r_tuser <= r_near[NP];
        end
    end
    assign o_m_tdata = r_tdata;
    assign o_m_tuser = r_tuser;

`ifndef SYNTH
    // A red step never overshoots when not snapping: q stays within the red channel's distance, or is at least 1 << CB.
    a_q_within_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NP] && !r_near[NP]) |->
        ((w_dir[0] ? (w_goal[0] - w_cur[0]) : (w_cur[0] - w_goal[0])) >= CB'(w_q[0])
         || w_q[0] >= QW'(1 << CB)))
        else $error("red step exceeds distance");

    // A pixel leaving the last pipeline stage while not stalled becomes a result.
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NP] && w_ce) |=> r_out_valid)
        else $error("result lost at output register");
`endif
endmodule

// File: hdl/cstt_lane.sv
// One color channel: distance terms and a pipelined bitwise search for the step.
module cstt_lane #(
    parameter int CHANNEL_BITS = cstt_pkg::CHANNEL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_ce,
    input  logic [CHANNEL_BITS-1:0]       i_cur,
    input  logic [CHANNEL_BITS-1:0]       i_goal,
    input  logic [cstt_pkg::STEP_BITS-1:0] i_step,
    output logic [2*CHANNEL_BITS-1:0]     o_sq,
    input  logic [2*CHANNEL_BITS+1:0]     i_sum,
    output logic [CHANNEL_BITS-1:0]       o_cur,
    output logic [CHANNEL_BITS-1:0]       o_goal,
    output logic                          o_dir,
    output logic [cstt_pkg::Q_BITS-1:0]   o_q
);
    localparam int CB = CHANNEL_BITS;
    localparam int SW = 2 * CB + 2;
    localparam int MW = CB + cstt_pkg::STEP_BITS;
    localparam int RW = 2 * MW;
    localparam int QW = cstt_pkg::Q_BITS;
    localparam int Q2W = cstt_pkg::Q2_BITS;
    localparam int NS = cstt_pkg::SEARCH_STAGES;
    localparam int PW = Q2W + SW;
    localparam int CW = (PW > RW) ? PW : RW;

    logic [CB-1:0]  r_cur1, r_goal1, r_mag1;
    logic           r_dir1;
    logic [CB-1:0]  r_cur2, r_goal2;
    logic           r_dir2;
    logic [2*CB-1:0] r_sq2;
    logic [MW-1:0]  r_ms2;
    logic [CB-1:0]  r_cur3, r_goal3;
    logic           r_dir3;
    logic [RW-1:0]  r_rhs3;

    logic [QW-1:0]  r_q   [1:NS];
    logic [Q2W-1:0] r_q2  [1:NS];
    logic [SW-1:0]  r_sum [1:NS];
    logic [RW-1:0]  r_rhs [1:NS];
    logic [CB-1:0]  r_cur [1:NS];
    logic [CB-1:0]  r_goal[1:NS];
    logic           r_dir [1:NS];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_cur1  <= i_cur;
            r_goal1 <= i_goal;
            r_dir1  <= (i_goal >= i_cur);
            r_mag1  <= (i_goal >= i_cur) ? (i_goal - i_cur) : (i_cur - i_goal);
            r_cur2  <= r_cur1;
            r_goal2 <= r_goal1;
            r_dir2  <= r_dir1;
            r_sq2   <= r_mag1 * r_mag1;
            r_ms2   <= MW'(r_mag1) * MW'(i_step);
            r_cur3  <= r_cur2;
            r_goal3 <= r_goal2;
            r_dir3  <= r_dir2;
            r_rhs3  <= RW'(r_ms2) * RW'(r_ms2);
        end
    end

    assign o_sq = r_sq2;

    // Stage k decides bit (NS-1-k) of q; the square of the trial value is
    // built from the square of the partial result with shifts and adds.
    for (genvar k = 0; k < NS; k++) begin : g_search
        localparam int B = NS - 1 - k;
        logic [QW-1:0]  w_q;
        logic [Q2W-1:0] w_q2;
        logic [SW-1:0]  w_sum;
        logic [RW-1:0]  w_rhs;
        logic [CB-1:0]  w_cur, w_goal;
        logic           w_dir;
        logic [QW-1:0]  w_t;
        logic [Q2W-1:0] w_t2;
        logic [PW-1:0]  w_prod;
        logic           w_take;

        if (k == 0) begin : g_first
            assign w_q    = '0;
            assign w_q2   = '0;
            assign w_sum  = i_sum;
            assign w_rhs  = r_rhs3;
            assign w_cur  = r_cur3;
            assign w_goal = r_goal3;
            assign w_dir  = r_dir3;
        end else begin : g_rest
            assign w_q    = r_q[k];
            assign w_q2   = r_q2[k];
            assign w_sum  = r_sum[k];
            assign w_rhs  = r_rhs[k];
            assign w_cur  = r_cur[k];
            assign w_goal = r_goal[k];
            assign w_dir  = r_dir[k];
        end

        assign w_t    = w_q | (QW'(1) << B);
        assign w_t2   = w_q2 + (Q2W'(w_q) << (B + 1)) + (Q2W'(1) << (2 * B));
        assign w_prod = PW'(w_t2) * PW'(w_sum);
        assign w_take = (CW'(w_prod) <= CW'(w_rhs));

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_q[k+1]    <= w_take ? w_t  : w_q;
                r_q2[k+1]   <= w_take ? w_t2 : w_q2;
                r_sum[k+1]  <= w_sum;
                r_rhs[k+1]  <= w_rhs;
                r_cur[k+1]  <= w_cur;
                r_goal[k+1] <= w_goal;
                r_dir[k+1]  <= w_dir;
            end
        end
    end

    assign o_cur  = r_cur[NS];
    assign o_goal = r_goal[NS];
    assign o_dir  = r_dir[NS];
    assign o_q    = r_q[NS];
endmodule
